/* design/slhp_pkg.sv */
// Shared types, phase codes and lookup functions for the syslog header parser.
// Depends on nothing; used by the top level.
package slhp_pkg;

  localparam logic [4:0] PH_LT    = 5'd0;
  localparam logic [4:0] PH_PRI   = 5'd1;
  localparam logic [4:0] PH_VER   = 5'd2;
  localparam logic [4:0] PH_MON2  = 5'd3;
  localparam logic [4:0] PH_MON3  = 5'd4;
  localparam logic [4:0] PH_OSP   = 5'd5;
  localparam logic [4:0] PH_ODAY  = 5'd6;
  localparam logic [4:0] PH_OHH   = 5'd7;
  localparam logic [4:0] PH_OMIN  = 5'd8;
  localparam logic [4:0] PH_OSEC  = 5'd9;
  localparam logic [4:0] PH_SKIP  = 5'd10;
  localparam logic [4:0] PH_YEAR  = 5'd11;
  localparam logic [4:0] PH_MONTH = 5'd12;
  localparam logic [4:0] PH_DAY   = 5'd13;
  localparam logic [4:0] PH_HOUR  = 5'd14;
  localparam logic [4:0] PH_MIN   = 5'd15;
  localparam logic [4:0] PH_SEC   = 5'd16;
  localparam logic [4:0] PH_FRAC  = 5'd17;
  localparam logic [4:0] PH_TZH   = 5'd18;
  localparam logic [4:0] PH_TZM   = 5'd19;
  localparam logic [4:0] PH_ZSP   = 5'd20;
  localparam logic [4:0] PH_HOST  = 5'd21;
  localparam logic [4:0] PH_BODY  = 5'd22;
  localparam logic [4:0] PH_DRAIN = 5'd23;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_TOK  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [0:0] REG_YEAR   = 1'b0;
  localparam logic [0:0] REG_OFFSET = 1'b1;

  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  // Records that can still arrive after ready was seen: two stages plus the new byte.
  localparam int FIFO_ROOM  = 9;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] start;
    logic [12:0] len;
    logic [1:0]  status;
    logic [12:0] total;
    logic        last;
  } slot_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [33:0] epoch;
    logic [30:0]        frac;
    logic [11:0]        start;
    logic [12:0]        len;
    logic [1:0]         status;
    logic [12:0]        total;
    logic               last;
  } rec_t;

  function automatic logic is_delim(input logic [7:0] b);
    logic r;
    case (b) inside
      8'h20, 8'h09, 8'h2C, 8'h2E, 8'h3A, 8'h3B, 8'h60, 8'h27, 8'h22, 8'h3C, 8'h3E,
      8'h5C, 8'h2F, 8'h7C, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h28, 8'h29, 8'h2B, 8'h2D,
      8'h2A, 8'h3D, 8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h3F:
        r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Month number 1..12 from three characters (first in the low byte), 0 if unknown.
  function automatic logic [3:0] month_num(input logic [23:0] m);
    logic [3:0] r;
    case (m) inside
      24'h6e614a, 24'h4e414a: r = 4'd1;
      24'h626546, 24'h424546: r = 4'd2;
      24'h72614d, 24'h52414d: r = 4'd3;
      24'h727041, 24'h525041: r = 4'd4;
      24'h79614d, 24'h59414d: r = 4'd5;
      24'h6e754a, 24'h4e554a: r = 4'd6;
      24'h6c754a, 24'h4c554a: r = 4'd7;
      24'h677541, 24'h475541: r = 4'd8;
      24'h706553, 24'h504553: r = 4'd9;
      24'h74634f, 24'h54434f: r = 4'd10;
      24'h766f4e, 24'h564f4e: r = 4'd11;
      24'h636544, 24'h434544: r = 4'd12;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] mo);
    logic [8:0] r;
    case (mo)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/slhp_ifs.sv */
// Handshake interfaces for the syslog header parser: message bytes in,
// records out, configuration writes. No dependencies.
interface slhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  modport source(output valid, data_byte, end_of_message, input ready);
  modport sink(input valid, data_byte, end_of_message, output ready);
endinterface

interface slhp_rec_if;
  logic               valid;
  logic               ready;
  logic [1:0]         record_kind;
  logic signed [33:0] epoch_seconds;
  logic [30:0]        fraction_value;
  logic [11:0]        span_start;
  logic [12:0]        span_length;
  logic [1:0]         status_code;
  logic [12:0]        token_total;
  logic               last_record;
  modport source(output valid, record_kind, epoch_seconds, fraction_value, span_start,
                 span_length, status_code, token_total, last_record, input ready);
  modport sink(input valid, record_kind, epoch_seconds, fraction_value, span_start,
               span_length, status_code, token_total, last_record, output ready);
endinterface

interface slhp_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [16:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* design/syslog_header_parse_tokenize_top.sv */
// Syslog header parser and tokenizer: one byte accepted per cycle while ready is high;
// its records pass stage 1 (parse), stage 2 (date arithmetic), then the FIFO (epoch).
// Throughput: one byte per cycle while the FIFO holds at most 7 records; a byte makes
// up to three records and the output drains one record per cycle while the sink is ready.
// Reset (synchronous rst): parser state cleared, year 2015, offset 0, FIFO empty.
// Depends on slhp_pkg and the interfaces in slhp_ifs.sv.
module syslog_header_parse_tokenize_top #(
  parameter int MAX_MESSAGE_BYTES = 4096,
  parameter int MAX_NUMBER_DIGITS = 15
) (
  input logic        clk,
  input logic        rst,
  slhp_byte_if.sink  msg_in,
  slhp_rec_if.source rec_out,
  slhp_cfg_if.sink   cfg
);
  import slhp_pkg::*;

  localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int DC_W  = $clog2(MAX_NUMBER_DIGITS + 2);
  localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_MESSAGE_BYTES);
  localparam logic [DC_W-1:0]  DC_LIM  = DC_W'(MAX_NUMBER_DIGITS);
  localparam logic [DC_W-1:0]  DC_SAT  = DC_W'(MAX_NUMBER_DIGITS + 1);

  // Configuration
  logic [11:0] cur_year;
  logic [16:0] loc_off;

  // Parser state
  logic [4:0]       phase, phase_next;
  logic [30:0]      acc, acc_next;
  logic [DC_W-1:0]  dcnt, dcnt_next;
  logic [15:0]      mon, mon_next;
  logic [11:0]      yr, yr_next;
  logic [3:0]       mo, mo_next;
  logic [4:0]       dd, dd_next, hh, hh_next;
  logic [5:0]       mi, mi_next, ss, ss_next;
  logic             zneg, zneg_next;
  logic [4:0]       zh, zh_next;
  logic [5:0]       zm, zm_next;
  logic             is_old, is_old_next;
  logic [16:0]      old_off, old_off_next;
  logic [30:0]      frac, frac_next;
  logic [OFF_W-1:0] boff, boff_next, span, span_next, toks, toks_next;
  logic             run_open, run_open_next, cut, cut_next;

  // Per-byte results
  slot_t       slot_n [3];
  logic [1:0]  nrec;
  logic [11:0] h_yr;
  logic [3:0]  h_mo;
  logic [4:0]  h_dd, h_hh, h_zh;
  logic [5:0]  h_mi, h_ss, h_zm;
  logic        h_zneg, h_old;
  logic [16:0] h_off;
  logic [30:0] h_frac;

  logic        take;
  logic [7:0]  b;
  logic        digit, zs, bad;
  logic [34:0] prod;
  logic [30:0] v;

  // Stage 1
  slot_t       s1_slot [3];
  logic [1:0]  s1_n;
  logic [11:0] s1_yr;
  logic [3:0]  s1_mo;
  logic [4:0]  s1_dd, s1_hh, s1_zh;
  logic [5:0]  s1_mi, s1_ss, s1_zm;
  logic        s1_zneg, s1_old;
  logic [16:0] s1_off;
  logic [30:0] s1_frac;

  // Stage 2
  slot_t        s2_slot [3];
  logic [1:0]   s2_n;
  logic [30:0]  s2_frac;
  logic [16:0]  s2_days, s2_sod;
  logic signed [17:0] s2_zoff;

  logic [7:0]   yo, lp;
  logic         leap_yr;
  logic [16:0]  days_c, sod_c, z_c;
  logic signed [17:0] zoff_c;
  logic [33:0]  wall;
  logic signed [35:0] ep;

  // Output FIFO
  rec_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_AW:0]   cnt;
  logic               pop;

  assign take = msg_in.valid && msg_in.ready;
  assign msg_in.ready = (cnt <= (FIFO_AW+1)'(FIFO_DEPTH - FIFO_ROOM));
  assign cfg.ready = 1'b1;
  assign b = msg_in.data_byte;
  assign digit = (b >= 8'h30) && (b <= 8'h39);
  assign zs = (b == 8'h5A) || (b == 8'h2B) || (b == 8'h2D);
  assign v = acc;
  assign prod = {acc, 3'b000} + {3'b000, acc, 1'b0} + {31'd0, b[3:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year <= 12'd2015;
      loc_off  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_YEAR:   cur_year <= cfg.data[11:0];
        REG_OFFSET: loc_off  <= cfg.data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;   acc_next = acc;       dcnt_next = dcnt;   mon_next = mon;
    yr_next = yr;         mo_next = mo;         dd_next = dd;       hh_next = hh;
    mi_next = mi;         ss_next = ss;         zneg_next = zneg;   zh_next = zh;
    zm_next = zm;         is_old_next = is_old; old_off_next = old_off;
    frac_next = frac;     boff_next = boff;     span_next = span;   toks_next = toks;
    run_open_next = run_open;                   cut_next = cut;
    nrec = 2'd0;
    bad = 1'b0;
    for (int k = 0; k < 3; k++) slot_n[k] = '0;

    if (take && !cut && (boff < OFF_MAX)) begin
      if (b == 8'h00) begin
        cut_next = 1'b1;
      end else begin
        boff_next = boff + 1'b1;
        if ((phase inside {[PH_ODAY:PH_OSEC], [PH_YEAR:PH_TZM]})) begin
          if (digit) begin
            acc_next = (prod > {4'd0, SAT31}) ? SAT31 : prod[30:0];
            if (dcnt != DC_SAT) dcnt_next = dcnt + 1'b1;
            if ((phase <= PH_OSEC) && (dcnt >= DC_LIM)) bad = 1'b1;
          end else if (dcnt == '0) begin
            bad = 1'b1;
          end else begin
            acc_next = '0;
            dcnt_next = '0;
            case (phase)
              PH_ODAY: begin
                if (b != 8'h20 || v < 31'd1 || v > 31'd31) bad = 1'b1;
                else begin dd_next = v[4:0]; phase_next = PH_OHH; end
              end
              PH_OHH: begin
                if (b != 8'h3A || v > 31'd23) bad = 1'b1;
                else begin hh_next = v[4:0]; phase_next = PH_OMIN; end
              end
              PH_OMIN: begin
                if (b != 8'h3A || v > 31'd59) bad = 1'b1;
                else begin mi_next = v[5:0]; phase_next = PH_OSEC; end
              end
              PH_OSEC: begin
                if (b != 8'h20 || v > 31'd60) bad = 1'b1;
                else begin
                  ss_next = v[5:0];
                  yr_next = (cur_year < 12'd1970) ? 12'd1970 :
                            (cur_year > 12'd2199) ? 12'd2199 : cur_year;
                  is_old_next = 1'b1;
                  old_off_next = loc_off;
                  frac_next = '0;
                  span_next = boff + 1'b1;
                  phase_next = PH_HOST;
                end
              end
              PH_YEAR: begin
                if (b != 8'h2D || v < 31'd1970 || v > 31'd2199) bad = 1'b1;
                else begin yr_next = v[11:0]; phase_next = PH_MONTH; end
              end
              PH_MONTH: begin
                if (b != 8'h2D || v < 31'd1 || v > 31'd12) bad = 1'b1;
                else begin mo_next = v[3:0]; phase_next = PH_DAY; end
              end
              PH_DAY: begin
                if (b != 8'h54 || v < 31'd1 || v > 31'd31) bad = 1'b1;
                else begin dd_next = v[4:0]; phase_next = PH_HOUR; end
              end
              PH_HOUR: begin
                if (b != 8'h3A || v > 31'd23) bad = 1'b1;
                else begin hh_next = v[4:0]; phase_next = PH_MIN; end
              end
              PH_MIN: begin
                if (b != 8'h3A || v > 31'd59) bad = 1'b1;
                else begin mi_next = v[5:0]; phase_next = PH_SEC; end
              end
              PH_SEC, PH_FRAC: begin
                if (phase == PH_SEC && (v > 31'd60 || !(zs || b == 8'h2E))) bad = 1'b1;
                else if (phase == PH_FRAC && !zs) bad = 1'b1;
                else begin
                  if (phase == PH_SEC) ss_next = v[5:0];
                  else frac_next = v;
                  zh_next = '0;
                  zm_next = '0;
                  zneg_next = 1'b0;
                  if (phase == PH_SEC && b == 8'h2E) phase_next = PH_FRAC;
                  else if (b == 8'h5A) phase_next = PH_ZSP;
                  else begin
                    zneg_next = (b == 8'h2D);
                    phase_next = PH_TZH;
                  end
                end
              end
              PH_TZH: begin
                if (b != 8'h3A || v > 31'd23) bad = 1'b1;
                else begin zh_next = v[4:0]; phase_next = PH_TZM; end
              end
              default: begin
                if (b != 8'h20 || v > 31'd59) bad = 1'b1;
                else begin
                  zm_next = v[5:0];
                  is_old_next = 1'b0;
                  span_next = boff + 1'b1;
                  phase_next = PH_HOST;
                end
              end
            endcase
          end
        end else begin
          case (phase)
            PH_LT: begin
              if (b == 8'h3C) phase_next = PH_PRI;
              else bad = 1'b1;
            end
            PH_PRI: begin
              if (b == 8'h3E) phase_next = PH_VER;
              else if (!digit) bad = 1'b1;
            end
            PH_VER: begin
              if (b == 8'h31) phase_next = PH_SKIP;
              else begin mon_next = {8'h00, b}; phase_next = PH_MON2; end
            end
            PH_MON2: begin
              mon_next = {b, mon[7:0]};
              phase_next = PH_MON3;
            end
            PH_MON3: begin
              if (month_num({b, mon}) == 4'd0) bad = 1'b1;
              else begin mo_next = month_num({b, mon}); phase_next = PH_OSP; end
            end
            PH_OSP: begin
              if (b != 8'h20) begin
                if (!digit) bad = 1'b1;
                else begin
                  acc_next = {27'd0, b[3:0]};
                  dcnt_next = DC_W'(1);
                  phase_next = PH_ODAY;
                end
              end
            end
            PH_SKIP: begin
              acc_next = '0;
              dcnt_next = '0;
              phase_next = PH_YEAR;
            end
            PH_ZSP: begin
              if (b == 8'h20) begin
                is_old_next = 1'b0;
                span_next = boff + 1'b1;
                phase_next = PH_HOST;
              end else bad = 1'b1;
            end
            PH_HOST: begin
              if (b == 8'h20) begin
                slot_n[nrec] = '{kind: KIND_HDR, start: 12'(span), len: 13'(boff - span),
                                 status: ST_OK, total: 13'd0, last: 1'b0};
                nrec = nrec + 1'b1;
                phase_next = PH_BODY;
                run_open_next = 1'b0;
              end
            end
            PH_BODY: begin
              if (is_delim(b)) begin
                if (run_open) begin
                  slot_n[nrec] = '{kind: KIND_TOK, start: 12'(span),
                                   len: 13'(boff - span), status: ST_OK,
                                   total: 13'd0, last: 1'b0};
                  nrec = nrec + 1'b1;
                  toks_next = toks_next + 1'b1;
                end
                run_open_next = 1'b0;
                slot_n[nrec] = '{kind: KIND_TOK, start: 12'(boff), len: 13'd1,
                                 status: ST_OK, total: 13'd0, last: 1'b0};
                nrec = nrec + 1'b1;
                toks_next = toks_next + 1'b1;
              end else if (!run_open) begin
                run_open_next = 1'b1;
                span_next = boff;
              end
            end
            default: ;
          endcase
        end
        if (bad) phase_next = PH_DRAIN;
      end
    end

    // Header fields as they stand after this byte, before an end clears them.
    h_yr = yr_next;   h_mo = mo_next;     h_dd = dd_next;       h_hh = hh_next;
    h_mi = mi_next;   h_ss = ss_next;     h_zneg = zneg_next;   h_zh = zh_next;
    h_zm = zm_next;   h_old = is_old_next; h_off = old_off_next; h_frac = frac_next;

    if (take && msg_in.end_of_message) begin
      if (phase_next == PH_HOST) begin
        slot_n[nrec] = '{kind: KIND_HDR, start: 12'(span_next),
                         len: (boff_next >= span_next) ? 13'(boff_next - span_next) : 13'd0,
                         status: ST_OK, total: 13'd0, last: 1'b0};
        nrec = nrec + 1'b1;
        slot_n[nrec] = '{kind: KIND_DONE, start: 12'd0, len: 13'd0, status: ST_EMPTY,
                         total: 13'(toks_next), last: 1'b1};
      end else if (phase_next == PH_BODY) begin
        if (run_open_next) begin
          slot_n[nrec] = '{kind: KIND_TOK, start: 12'(span_next),
                           len: 13'(boff_next - span_next), status: ST_OK,
                           total: 13'd0, last: 1'b0};
          nrec = nrec + 1'b1;
          toks_next = toks_next + 1'b1;
        end
        slot_n[nrec] = '{kind: KIND_DONE, start: 12'd0, len: 13'd0,
                         status: (toks_next != '0) ? ST_OK : ST_EMPTY,
                         total: 13'(toks_next), last: 1'b1};
      end else begin
        slot_n[nrec] = '{kind: KIND_DONE, start: 12'd0, len: 13'd0, status: ST_ERR,
                         total: 13'(toks_next), last: 1'b1};
      end
      nrec = nrec + 1'b1;
      phase_next = PH_LT;   acc_next = '0;     dcnt_next = '0;    mon_next = '0;
      yr_next = '0;         mo_next = '0;      dd_next = '0;      hh_next = '0;
      mi_next = '0;         ss_next = '0;      zneg_next = 1'b0;  zh_next = '0;
      zm_next = '0;         is_old_next = 1'b0; old_off_next = '0; frac_next = '0;
      boff_next = '0;       span_next = '0;    toks_next = '0;
      run_open_next = 1'b0; cut_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LT;   acc <= '0;     dcnt <= '0;    mon <= '0;
      yr <= '0;         mo <= '0;      dd <= '0;      hh <= '0;
      mi <= '0;         ss <= '0;      zneg <= 1'b0;  zh <= '0;
      zm <= '0;         is_old <= 1'b0; old_off <= '0; frac <= '0;
      boff <= '0;       span <= '0;    toks <= '0;
      run_open <= 1'b0; cut <= 1'b0;
    end else begin
      phase <= phase_next;   acc <= acc_next;       dcnt <= dcnt_next;  mon <= mon_next;
      yr <= yr_next;         mo <= mo_next;         dd <= dd_next;      hh <= hh_next;
      mi <= mi_next;         ss <= ss_next;         zneg <= zneg_next;  zh <= zh_next;
      zm <= zm_next;         is_old <= is_old_next; old_off <= old_off_next;
      frac <= frac_next;     boff <= boff_next;     span <= span_next;  toks <= toks_next;
      run_open <= run_open_next;                    cut <= cut_next;
    end
  end

  // Stage 1: records and header fields of one byte.
  always_ff @(posedge clk) begin
    if (rst) s1_n <= 2'd0;
    else s1_n <= nrec;
    s1_slot <= slot_n;
    s1_yr <= h_yr;  s1_mo <= h_mo;  s1_dd <= h_dd;  s1_hh <= h_hh;
    s1_mi <= h_mi;  s1_ss <= h_ss;  s1_zneg <= h_zneg;  s1_zh <= h_zh;
    s1_zm <= h_zm;  s1_old <= h_old; s1_off <= h_off;  s1_frac <= h_frac;
  end

  // Leap days from 1970 to the start of the year; 2100 is the only skipped one in range.
  always_comb begin
    yo = 8'(s1_yr - 12'd1970);
    lp = 8'((s1_yr - 12'd1969) >> 2) - ((s1_yr > 12'd2100) ? 8'd1 : 8'd0);
    leap_yr = (s1_yr[1:0] == 2'b00) && (s1_yr != 12'd2100);
    days_c = 17'(yo * 17'd365) + 17'(lp) + 17'(days_before(s1_mo))
           + (((s1_mo > 4'd2) && leap_yr) ? 17'd1 : 17'd0) + 17'(s1_dd) - 17'd1;
    sod_c = 17'(s1_hh * 17'd3600) + 17'(s1_mi * 17'd60) + 17'(s1_ss);
    z_c = 17'(s1_zh * 17'd3600) + 17'(s1_zm * 17'd60);
    // The offset is subtracted from wall time; a minus zone adds its hours.
    if (s1_old) zoff_c = {s1_off[16], s1_off};
    else if (s1_zneg) zoff_c = -$signed({1'b0, z_c});
    else zoff_c = $signed({1'b0, z_c});
  end

  always_ff @(posedge clk) begin
    if (rst) s2_n <= 2'd0;
    else s2_n <= s1_n;
    s2_slot <= s1_slot;
    s2_frac <= s1_frac;
    s2_days <= days_c;
    s2_sod  <= sod_c;
    s2_zoff <= zoff_c;
  end

  assign wall = s2_days * 17'd86400;
  assign ep = $signed({2'b00, wall}) + $signed({19'd0, s2_sod})
            - $signed({{18{s2_zoff[17]}}, s2_zoff});

  assign pop = rec_out.valid && rec_out.ready;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < s2_n) begin
        mem[wptr + FIFO_AW'(k)] <= '{
          kind:   s2_slot[k].kind,
          epoch:  (s2_slot[k].kind == KIND_HDR) ? ep[33:0] : 34'sd0,
          frac:   (s2_slot[k].kind == KIND_HDR) ? s2_frac : 31'd0,
          start:  s2_slot[k].start,
          len:    s2_slot[k].len,
          status: s2_slot[k].status,
          total:  s2_slot[k].total,
          last:   s2_slot[k].last};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      wptr <= wptr + FIFO_AW'(s2_n);
      if (pop) rptr <= rptr + 1'b1;
      cnt <= cnt + (FIFO_AW+1)'(s2_n) - ((FIFO_AW+1)'(pop));
    end
  end

  assign rec_out.valid          = (cnt != '0);
  assign rec_out.record_kind    = mem[rptr].kind;
  assign rec_out.epoch_seconds  = mem[rptr].epoch;
  assign rec_out.fraction_value = mem[rptr].frac;
  assign rec_out.span_start     = mem[rptr].start;
  assign rec_out.span_length    = mem[rptr].len;
  assign rec_out.status_code    = mem[rptr].status;
  assign rec_out.token_total    = mem[rptr].total;
  assign rec_out.last_record    = mem[rptr].last;

`ifndef SYNTH
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("output FIFO overflow");

  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    rec_out.valid |-> (rec_out.last_record == (rec_out.record_kind == KIND_DONE)))
    else $error("last_record does not match a done record");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (take && msg_in.end_of_message) |=> (phase == PH_LT && boff == '0 && toks == '0))
    else $error("parser not cleared after end of message");

  a_no_late_bytes: assert property (@(posedge clk) disable iff (rst)
    (cut && !(take && msg_in.end_of_message)) |=> $stable(boff))
    else $error("byte offset moved after a zero byte");
`endif

endmodule
